// ----- hw/rtl/bndf_pkg.sv -----
// Shared types and constants of the binary neighbour density filter.
`timescale 1ns / 1ps
`default_nettype none

package bndf_pkg;

  typedef struct packed {
    logic [7:0] pixel;
    logic       frame_start;
  } in_item_t;

  typedef struct packed {
    logic [7:0]  filtered_pixel;
    logic [11:0] out_row;
    logic [9:0]  out_col;
    logic        frame_last;
  } out_item_t;

  // Register map: byte address 4*index
  typedef enum logic [1:0] {
    REG_IMAGE_WIDTH  = 2'd0,
    REG_IMAGE_HEIGHT = 2'd1,
    REG_MIN_DENSITY  = 2'd2,
    REG_FG_VALUE     = 2'd3
  } reg_index_t;

  localparam logic [10:0] IMAGE_WIDTH_RESET  = 11'd640;
  localparam logic [11:0] IMAGE_HEIGHT_RESET = 12'd480;
  localparam logic [3:0]  MIN_DENSITY_RESET  = 4'd4;
  localparam logic [7:0]  FG_VALUE_RESET     = 8'd255;

  // Output queue depth: one entry for the item being shown, one for the
  // window stage, one for the item accepted behind it
  localparam int unsigned OUT_DEPTH = 3;

  // One column of the two line stores
  typedef struct packed {
    logic upper;
    logic middle;
  } line_bits_t;

  // Window stage control, carried from the accepting edge
  typedef struct packed {
    logic        valid;
    logic        emit;
    logic        fwd;
    logic        match;
    logic        last;
    logic [11:0] row;
    logic [9:0]  col;
  } win_ctrl_t;

endpackage

`default_nettype wire

// ----- hw/rtl/bndf_line_mem.sv -----
// Line store memory: upper and middle match bits per column, registered read.
`timescale 1ns / 1ps
`default_nettype none

module bndf_line_mem #(
  parameter int DEPTH = 1024,
  parameter int AW    = $clog2(DEPTH)
) (
  input  wire                 clk,
  input  wire                 rd_en,
  input  wire  [AW-1:0]       rd_addr,
  output bndf_pkg::line_bits_t rd_data,
  input  wire                 wr_en,
  input  wire  [AW-1:0]       wr_addr,
  input  bndf_pkg::line_bits_t wr_data
);

  bndf_pkg::line_bits_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/bndf_window.sv -----
// Window stage: 3x3 match window, line store write-back and density decision.
`timescale 1ns / 1ps
`default_nettype none

module bndf_window (
  input  wire                  clk,
  input  wire                  rst,
  input  bndf_pkg::win_ctrl_t  ctrl,
  input  bndf_pkg::line_bits_t rd_data,
  input  wire  [3:0]           min_density,
  input  wire  [7:0]           fg_value,
  output bndf_pkg::line_bits_t wr_data,
  output bndf_pkg::out_item_t  result
);

  logic [8:0]           window;
  logic [8:0]           window_next;
  bndf_pkg::line_bits_t wr_prev;
  bndf_pkg::line_bits_t line;
  logic [3:0]           neigh;

  // Same column written by the item just before: memory read saw old data
  assign line = ctrl.fwd ? wr_prev : rd_data;

  // column bits: bit0 top, bit1 middle, bit2 incoming
  assign window_next = {window[5:0], ctrl.match, line.middle, line.upper};

  assign wr_data.upper  = line.middle;
  assign wr_data.middle = ctrl.match;

  always_comb begin
    neigh = 4'd0;
    for (int i = 0; i < 9; i++) begin
      if (i != 4) begin
        neigh = neigh + {3'd0, window_next[i]};
      end
    end
  end

  always_comb begin
    result.filtered_pixel = (window_next[4] && (neigh >= min_density)) ? fg_value : 8'd0;
    result.out_row        = ctrl.row;
    result.out_col        = ctrl.col;
    result.frame_last     = ctrl.last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      window <= 9'd0;
    end else if (ctrl.valid) begin
      window <= window_next;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.valid) begin
      wr_prev <= wr_data;
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/bndf_out_fifo.sv -----
// Three-entry output queue that parts the window stage from the output stall.
`timescale 1ns / 1ps
`default_nettype none

module bndf_out_fifo (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 push,
  input  bndf_pkg::out_item_t push_data,
  output logic                out_valid,
  input  wire                 out_stall,
  output bndf_pkg::out_item_t out_data,
  output logic [1:0]          level
);

  localparam logic [1:0] LAST_PTR = 2'(bndf_pkg::OUT_DEPTH - 1);

  bndf_pkg::out_item_t entries [bndf_pkg::OUT_DEPTH];
  logic [1:0] wptr;
  logic [1:0] rptr;
  logic       pop;

  assign out_valid = (level != 2'd0);
  assign pop       = out_valid && !out_stall;
  assign out_data  = entries[rptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 2'd0;
      rptr  <= 2'd0;
      level <= 2'd0;
    end else begin
      if (push) begin
        wptr <= (wptr == LAST_PTR) ? 2'd0 : wptr + 2'd1;
      end
      if (pop) begin
        rptr <= (rptr == LAST_PTR) ? 2'd0 : rptr + 2'd1;
      end
      priority if (push && !pop) begin
        level <= level + 2'd1;
      end else if (pop && !push) begin
        level <= level - 2'd1;
      end else begin
        level <= level;
      end
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/binary_neighbour_density_filter.sv -----
// Top level of the binary neighbour density filter: registers, position and pipeline.
`timescale 1ns / 1ps
`default_nettype none

// Takes one mask pixel per clock in raster order while in_stall is low and
// gives one result per interior pixel (rows 1 to height-2, columns 1 to
// width-2 of the centre): fg_value when the pixel matches and at least
// min_density of its eight neighbours match, else 0. An item is accepted at
// the edge where the line store memory is read; the next edge updates the
// 3x3 window, writes the column back and pushes the result into the output
// queue, whose registered level drives out_valid. A three-entry output queue
// absorbs short output stalls with no gap at the input; in_stall rises only
// when that queue and the window stage would overflow. The line stores need
// no clearing after reset.
// Geometry registers should only change between frames.
module binary_neighbour_density_filter #(
  parameter int MAX_WIDTH = 1024
) (
  input  wire                  clk,
  input  wire                  rst,
  input  wire                  in_valid,
  output logic                 in_stall,
  input  bndf_pkg::in_item_t   in_data,
  output logic                 out_valid,
  input  wire                  out_stall,
  output bndf_pkg::out_item_t  out_data,
  input  wire                  psel,
  input  wire                  penable,
  input  wire                  pwrite,
  input  wire  [3:0]           paddr,
  input  wire  [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);

  localparam int COLW = $clog2(MAX_WIDTH);
  localparam int WW   = (COLW + 1 > 11) ? COLW + 1 : 11;
  localparam logic [WW-1:0] MAX_W = WW'(MAX_WIDTH);

  // configuration registers
  logic [10:0] image_width;
  logic [11:0] image_height;
  logic [3:0]  min_density;
  logic [7:0]  fg_value;

  logic        cfg_wr;
  bndf_pkg::reg_index_t cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign cfg_idx = bndf_pkg::reg_index_t'(paddr[3:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= bndf_pkg::IMAGE_WIDTH_RESET;
      image_height <= bndf_pkg::IMAGE_HEIGHT_RESET;
      min_density  <= bndf_pkg::MIN_DENSITY_RESET;
      fg_value     <= bndf_pkg::FG_VALUE_RESET;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        bndf_pkg::REG_IMAGE_WIDTH:  image_width  <= pwdata[10:0];
        bndf_pkg::REG_IMAGE_HEIGHT: image_height <= pwdata[11:0];
        bndf_pkg::REG_MIN_DENSITY:  min_density  <= pwdata[3:0];
        bndf_pkg::REG_FG_VALUE:     fg_value     <= pwdata[7:0];
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      bndf_pkg::REG_IMAGE_WIDTH:  prdata = {21'd0, image_width};
      bndf_pkg::REG_IMAGE_HEIGHT: prdata = {20'd0, image_height};
      bndf_pkg::REG_MIN_DENSITY:  prdata = {28'd0, min_density};
      bndf_pkg::REG_FG_VALUE:     prdata = {24'd0, fg_value};
    endcase
  end

  // geometry, saturated where used
  logic [WW-1:0] w_ext;
  logic [WW-1:0] w_sat;
  logic [11:0]   h_sat;

  assign w_ext = WW'(image_width);

  always_comb begin
    priority if (w_ext < WW'(3)) begin
      w_sat = WW'(3);
    end else if (w_ext > MAX_W) begin
      w_sat = MAX_W;
    end else begin
      w_sat = w_ext;
    end
    h_sat = (image_height < 12'd3) ? 12'd3 : image_height;
  end

  // position and acceptance
  logic [COLW-1:0] col_position;
  logic [11:0]     row_position;
  logic [COLW-1:0] col;
  logic [WW-1:0]   col_w;
  logic [WW-1:0]   col_inc;
  logic [WW-1:0]   col_dec;
  logic [11:0]     row;
  logic [12:0]     row_inc;
  logic [COLW-1:0] col_position_next;
  logic [11:0]     row_position_next;
  logic            accept;
  logic [1:0]      level;

  bndf_pkg::win_ctrl_t  ctrl;
  bndf_pkg::win_ctrl_t  ctrl_next;
  logic [COLW-1:0]      ctrl_col;
  bndf_pkg::line_bits_t rd_data;
  bndf_pkg::line_bits_t wr_data;
  bndf_pkg::out_item_t  result;

  // occupancy of window stage plus queue bounds what may still arrive
  assign in_stall = ({1'b0, level} + {2'd0, ctrl.valid}) >= 3'(bndf_pkg::OUT_DEPTH);
  assign accept   = in_valid && !in_stall;

  always_comb begin
    logic [WW-1:0] c_raw;
    c_raw = in_data.frame_start ? '0 : WW'(col_position);
    col   = (c_raw >= MAX_W) ? COLW'(MAX_WIDTH - 1) : c_raw[COLW-1:0];
    row   = in_data.frame_start ? 12'd0 : row_position;
    col_w   = WW'(col);
    col_inc = col_w + WW'(1);
    col_dec = col_w - WW'(1);
    row_inc = {1'b0, row} + 13'd1;

    if (col_inc >= w_sat) begin
      col_position_next = '0;
      row_position_next = (row_inc >= {1'b0, h_sat}) ? 12'd0 : row_inc[11:0];
    end else begin
      col_position_next = col_inc[COLW-1:0];
      row_position_next = row;
    end

    ctrl_next.valid = 1'b1;
    ctrl_next.emit  = (row >= 12'd2) && (row < h_sat) && (col_w >= WW'(2)) && (col_w < w_sat);
    ctrl_next.fwd   = ctrl.valid && (ctrl_col == col);
    ctrl_next.match = (in_data.pixel == fg_value);
    ctrl_next.last  = (row == h_sat - 12'd1) && (col_w == w_sat - WW'(1));
    ctrl_next.row   = row - 12'd1;
    ctrl_next.col   = col_dec[9:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col_position <= '0;
      row_position <= 12'd0;
    end else if (accept) begin
      col_position <= col_position_next;
      row_position <= row_position_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctrl.valid <= 1'b0;
    end else if (accept) begin
      ctrl <= ctrl_next;
    end else begin
      ctrl.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      ctrl_col <= col;
    end
  end

  bndf_line_mem #(
    .DEPTH (MAX_WIDTH),
    .AW    (COLW)
  ) u_line_mem (
    .clk     (clk),
    .rd_en   (accept),
    .rd_addr (col),
    .rd_data (rd_data),
    .wr_en   (ctrl.valid),
    .wr_addr (ctrl_col),
    .wr_data (wr_data)
  );

  bndf_window u_window (
    .clk         (clk),
    .rst         (rst),
    .ctrl        (ctrl),
    .rd_data     (rd_data),
    .min_density (min_density),
    .fg_value    (fg_value),
    .wr_data     (wr_data),
    .result      (result)
  );

  bndf_out_fifo u_out_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (ctrl.valid && ctrl.emit),
    .push_data (result),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .level     (level)
  );

  a_accept_to_window: assert property (@(posedge clk) disable iff (rst)
    accept |=> ctrl.valid)
    else $error("accepted item did not reach the window stage");

  a_fwd_same_col: assert property (@(posedge clk) disable iff (rst)
    (ctrl.valid && ctrl.fwd) |-> ($past(ctrl_col) == ctrl_col))
    else $error("forwarding flagged for a different column");

  a_queue_full_no_stage: assert property (@(posedge clk) disable iff (rst)
    (level == 2'd3) |-> !ctrl.valid)
    else $error("output queue full with an item still in the window stage");

endmodule

`default_nettype wire

// ----- dv/tb_top.sv -----
// Testbench for the binary neighbour density filter: streamed frames against a predictor.
`timescale 1ns / 1ps

module tb_top;

  localparam int MAX_W        = 1024;
  localparam int CYCLE_LIMIT  = 2000000;
  localparam int RANDOM_ITEMS = 420;
  localparam int HOLD_AFTER   = 20;
  localparam int HOLD_CYCLES  = 400;
  localparam int DRAIN_CYCLES = 8;

  logic                clk       = 1'b0;
  logic                rst       = 1'b1;
  logic                in_valid  = 1'b0;
  logic                in_stall;
  bndf_pkg::in_item_t  in_data   = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  bndf_pkg::out_item_t out_data;
  logic                psel      = 1'b0;
  logic                penable   = 1'b0;
  logic                pwrite    = 1'b0;
  logic [3:0]          paddr     = '0;
  logic [31:0]         pwdata    = '0;
  logic [31:0]         prdata;
  logic                pready;

  binary_neighbour_density_filter dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  always #1 clk = ~clk;

  // Register copies as the predictor sees them
  logic [10:0] cfg_width   = bndf_pkg::IMAGE_WIDTH_RESET;
  logic [11:0] cfg_height  = bndf_pkg::IMAGE_HEIGHT_RESET;
  logic [3:0]  cfg_density = bndf_pkg::MIN_DENSITY_RESET;
  logic [7:0]  cfg_fg      = bndf_pkg::FG_VALUE_RESET;

  // Predictor state
  logic        upper_bits [MAX_W];
  logic        middle_bits [MAX_W];
  logic [8:0]  window_bits = '0;
  int unsigned cur_row = 0;
  int unsigned cur_col = 0;

  bndf_pkg::in_item_t  pixel_q[$];
  bndf_pkg::out_item_t expected_px[$];

  int        errors = 0;
  int        cycles = 0;
  int        burst_left = 0;
  int        gap_left = 0;
  int        results_seen = 0;
  int        hold_left = 0;
  bit        hold_done = 1'b0;
  int        run_left = 0;
  bit        stall_state = 1'b0;
  bndf_pkg::out_item_t want;

  initial begin
    for (int i = 0; i < MAX_W; i++) begin
      upper_bits[i] = 1'b0;
      middle_bits[i] = 1'b0;
    end
  end

  task automatic filter_pixel(input bndf_pkg::in_item_t it);
    int unsigned         w, h, c, r, neigh;
    int                  i;
    bndf_pkg::out_item_t res;
    w = 32'(cfg_width);
    if (w < 3) w = 3;
    if (w > MAX_W) w = MAX_W;
    h = 32'(cfg_height);
    if (h < 3) h = 3;
    if (it.frame_start) begin
      cur_row = 0;
      cur_col = 0;
    end
    c = cur_col;
    r = cur_row;
    if (c >= MAX_W) c = MAX_W - 1;
    // new column enters at the bottom bits: {match, middle, upper}
    window_bits = {window_bits[5:0], it.pixel == cfg_fg, middle_bits[c], upper_bits[c]};
    upper_bits[c] = middle_bits[c];
    middle_bits[c] = (it.pixel == cfg_fg);
    if (r >= 2 && r < h && c >= 2 && c < w) begin
      neigh = 0;
      for (i = 0; i < 9; i++) begin
        if (i != 4) neigh += window_bits[i];
      end
      res.filtered_pixel = (window_bits[4] && neigh >= cfg_density) ? cfg_fg : 8'd0;
      res.out_row = 12'(r - 1);
      res.out_col = 10'(c - 1);
      res.frame_last = (r == h - 1 && c == w - 1);
      expected_px.push_back(res);
    end
    c++;
    if (c >= w) begin
      c = 0;
      r++;
      if (r >= h) r = 0;
    end
    cur_col = c;
    cur_row = r & 12'hFFF;
  endtask

  task automatic write_reg(input bndf_pkg::reg_index_t idx, input logic [31:0] val);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  // Upper bits carry junk; only the field width is kept
  task automatic set_config(input int w, input int h, input int d, input int fgv);
    logic [31:0] v;
    v = $urandom();
    v[10:0] = 11'(w);
    write_reg(bndf_pkg::REG_IMAGE_WIDTH, v);
    v = $urandom();
    v[11:0] = 12'(h);
    write_reg(bndf_pkg::REG_IMAGE_HEIGHT, v);
    v = $urandom();
    v[3:0] = 4'(d);
    write_reg(bndf_pkg::REG_MIN_DENSITY, v);
    v = $urandom();
    v[7:0] = 8'(fgv);
    write_reg(bndf_pkg::REG_FG_VALUE, v);
    cfg_width = 11'(w);
    cfg_height = 12'(h);
    cfg_density = 4'(d);
    cfg_fg = 8'(fgv);
  endtask

  task automatic queue_pixels(input int n, input bit start, input int pct, input bit stray);
    bndf_pkg::in_item_t it;
    int                 k;
    for (k = 0; k < n; k++) begin
      if ($urandom_range(0, 99) < pct) begin
        it.pixel = cfg_fg;
      end else begin
        it.pixel = 8'($urandom_range(0, 255));
      end
      it.frame_start = (k == 0) ? start : (stray && $urandom_range(0, 29) == 0);
      pixel_q.push_back(it);
    end
  endtask

  // Border items give no result, so allow the pipeline to drain afterwards
  task automatic wait_idle();
    while (pixel_q.size() != 0 || in_valid || expected_px.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Sender: bursts of items with gaps; a waiting item is held until taken
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) filter_pixel(in_data);
      if (!in_valid || !in_stall) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (pixel_q.size() > 0) begin
          in_data <= pixel_q.pop_front();
          in_valid <= 1'b1;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(100, 300)
                                                     : $urandom_range(1, 30);
            gap_left = $urandom_range(0, 6);
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: checks each result and stalls on its own pattern
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        results_seen++;
        if (expected_px.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("unexpected result: pix %0d row %0d col %0d last %0b",
                     out_data.filtered_pixel, out_data.out_row, out_data.out_col,
                     out_data.frame_last);
        end else begin
          want = expected_px.pop_front();
          if (out_data.filtered_pixel !== want.filtered_pixel ||
              out_data.out_row !== want.out_row ||
              out_data.out_col !== want.out_col ||
              out_data.frame_last !== want.frame_last) begin
            errors++;
            if (errors <= 10)
              $display("mismatch: exp %0d/%0d/%0d/%0b got %0d/%0d/%0d/%0b",
                       want.filtered_pixel, want.out_row, want.out_col, want.frame_last,
                       out_data.filtered_pixel, out_data.out_row, out_data.out_col,
                       out_data.frame_last);
          end
        end
      end
      // one long hold-off so the block fills and pushes back on its input
      if (!hold_done && results_seen >= HOLD_AFTER) begin
        hold_left = HOLD_CYCLES;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
      end else if (run_left > 0) begin
        run_left--;
      end else begin
        stall_state = !stall_state;
        if (stall_state) begin
          run_left = $urandom_range(0, 5);
        end else begin
          run_left = ($urandom_range(0, 5) == 0) ? $urandom_range(50, 150)
                                                 : $urandom_range(0, 12);
        end
      end
      out_stall <= (hold_left > 0) || stall_state;
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles == CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    int                 w, h, weff, heff, n, kind, frames, f, sent, pct, fgv, i;
    bit                 start_bit;
    bit                 stray_bit;
    bndf_pkg::in_item_t it;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // reset geometry: two full rows of 640 and the start of a third
    queue_pixels(2 * 640 + 40, 1'b1, 70, 1'b0);
    wait_idle();

    // lone foreground centre kept at density 0; width and height saturate to 3
    set_config(2, 0, 0, 255);
    for (i = 0; i < 9; i++) begin
      it.pixel = (i == 4) ? 8'hFF : 8'h00;
      it.frame_start = (i == 0);
      pixel_q.push_back(it);
    end
    wait_idle();
    set_config(3, 3, 8, 8'hA5);
    queue_pixels(9, 1'b1, 100, 1'b0);
    wait_idle();
    // density above eight clears a fully lit frame
    set_config(3, 3, 9, 8'hA5);
    queue_pixels(9, 1'b1, 100, 1'b0);
    wait_idle();

    // tallest frame, only the top part streamed
    set_config(3, 4095, 3, 0);
    queue_pixels(3 * 40, 1'b1, 60, 1'b0);
    wait_idle();

    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      case ($urandom_range(0, 9))
        0: w = $urandom_range(0, 2);
        1: w = $urandom_range(17, 64);
        default: w = $urandom_range(3, 16);
      endcase
      case ($urandom_range(0, 9))
        0: h = $urandom_range(0, 2);
        1: h = $urandom_range(13, 4095);
        default: h = $urandom_range(3, 12);
      endcase
      case ($urandom_range(0, 3))
        0: fgv = 0;
        1: fgv = 255;
        default: fgv = $urandom_range(0, 255);
      endcase
      set_config(w, h, $urandom_range(0, 15), fgv);
      weff = (w < 3) ? 3 : w;
      heff = (h < 3) ? 3 : h;
      if (heff > 16) heff = 16;
      frames = $urandom_range(1, 3);
      for (f = 0; f < frames && sent < RANDOM_ITEMS; f++) begin
        pct = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 100) : $urandom_range(50, 95);
        kind = (f == 0) ? 2 : $urandom_range(0, 9);
        n = weff * heff;
        start_bit = 1'b1;
        stray_bit = ($urandom_range(0, 9) == 0);
        case (kind)
          0: begin
            // noise: arbitrary run length and stray frame starts
            n = $urandom_range(1, weff * heff);
            start_bit = 1'($urandom_range(0, 1));
            stray_bit = 1'b1;
          end
          1: begin
            // no frame start: relies on the position wrapping
            start_bit = 1'b0;
            stray_bit = 1'b0;
          end
          default: begin
          end
        endcase
        if (n > RANDOM_ITEMS - sent) n = RANDOM_ITEMS - sent;
        queue_pixels(n, start_bit, pct, stray_bit);
        sent += n;
      end
      wait_idle();
    end

    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
hw/rtl/bndf_pkg.sv
hw/rtl/bndf_line_mem.sv
hw/rtl/bndf_window.sv
hw/rtl/bndf_out_fifo.sv
hw/rtl/binary_neighbour_density_filter.sv
dv/tb_top.sv
